// ===== design/kld_pkg.sv =====
// shared types and constants for the kth largest common divisor unit
package kld_pkg;

    localparam int RANK_BITS = 20;

    // one-hot sequencer states
    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_GCD    = 8'b0000_0010,
        S_TRIAL  = 8'b0000_0100,
        S_DIVW   = 8'b0000_1000,
        S_SELECT = 8'b0001_0000,
        S_RDW    = 8'b0010_0000,
        S_QDIV   = 8'b0100_0000,
        S_OUT    = 8'b1000_0000
    } t_state;

endpackage

// ===== design/kld_ram.sv =====
// generic single-port-write, registered-read ram
module kld_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== design/kld_div.sv =====
// restoring divider, one quotient bit per cycle
module kld_div #(
    parameter int VALUE_BITS = 40
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [VALUE_BITS-1:0] i_dividend,
    input  logic [VALUE_BITS-1:0] i_divisor,
    output logic                  o_done,
    output logic [VALUE_BITS-1:0] o_quotient,
    output logic [VALUE_BITS-1:0] o_remainder
);
    localparam int NW = $clog2(VALUE_BITS + 1);

    logic                  r_busy;
    logic                  r_done;
    logic [NW-1:0]         r_cnt;
    logic [VALUE_BITS-1:0] r_rem;
    logic [VALUE_BITS-1:0] r_quo;
    logic [VALUE_BITS-1:0] r_dvs;
    logic [VALUE_BITS:0]   trial;
    logic                  fits;

    // shift in next dividend bit and try the subtract
    assign trial = {r_rem, r_quo[VALUE_BITS-1]};
    assign fits  = trial >= {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= !i_start && r_busy && (r_cnt == NW'(1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= NW'(VALUE_BITS);
                r_rem  <= '0;
                r_quo  <= i_dividend;
                r_dvs  <= i_divisor;
            end else if (r_busy) begin
                r_rem <= fits ? VALUE_BITS'(trial - {1'b0, r_dvs}) : trial[VALUE_BITS-1:0];
                r_quo <= {r_quo[VALUE_BITS-2:0], fits};
                r_cnt <= r_cnt - NW'(1);
                if (r_cnt == NW'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;
endmodule

// ===== design/kth_largest_common_divisor_unit.sv =====
// top level: gcd, trial division into a divisor store, rank selection
// sequence: binary gcd, then trial division of g by each candidate d up to sqrt(g)
// in the shared restoring divider, then one more division when the rank picks a large divisor
// throughput: one request at a time; a new request is accepted only in the idle state
// reset: synchronous active low, clears sequencer and output valid; store is not cleared
module kth_largest_common_divisor_unit #(
    parameter int VALUE_BITS    = 40,
    parameter int DIVISOR_DEPTH = 4096
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_s_tvalid,
    output logic o_s_tready,
    // first_value, second_value, rank, zero pad
    input  logic [((2*VALUE_BITS+kld_pkg::RANK_BITS+7)/8)*8-1:0] i_s_tdata,
    output logic o_m_tvalid,
    input  logic i_m_tready,
    // divisor, zero pad
    output logic [((VALUE_BITS+7)/8)*8-1:0] o_m_tdata,
    // found
    output logic o_m_tuser
);
    import kld_pkg::*;

    localparam int AW   = $clog2(DIVISOR_DEPTH);
    localparam int CW   = AW + 1;
    localparam int SQW  = VALUE_BITS + 2;
    localparam int SW   = $clog2(VALUE_BITS + 1);
    localparam int CMPW = ((CW + 1 > RANK_BITS) ? CW + 1 : RANK_BITS) + 1;
    localparam int OW   = ((VALUE_BITS+7)/8)*8;

    t_state                r_state, n_state;
    logic [VALUE_BITS-1:0] r_a, r_b, r_g, r_d, r_ans;
    logic [SW-1:0]         r_sh;
    logic [SQW-1:0]        r_sq;
    logic [CW-1:0]         r_cnt;
    logic                  r_square, r_large, r_found;
    logic [RANK_BITS-1:0]  r_k;
    logic                  r_ovalid, r_ofound;
    logic [VALUE_BITS-1:0] r_odata;

    logic                  div_start, div_done;
    logic [VALUE_BITS-1:0] div_dividend, div_divisor, div_quo, div_rem;
    logic                  ram_we;
    logic [AW-1:0]         ram_raddr;
    logic [VALUE_BITS-1:0] ram_rdata;

    logic [CMPW-1:0] s_ext, k_ext, total;
    logic            sel_ok, sel_large;

    // rank selection over small and large divisors
    assign s_ext     = CMPW'(r_cnt);
    assign k_ext     = CMPW'(r_k);
    assign total     = (s_ext << 1) - CMPW'(r_square);
    assign sel_ok    = (r_cnt != '0) && (r_k != '0) && (k_ext <= total);
    assign sel_large = k_ext <= s_ext;
    assign ram_raddr = sel_large ? AW'(k_ext - CMPW'(1)) : AW'(total - k_ext);

    // divider sharing: trial remainder or final quotient
    always_comb begin
        div_start    = 1'b0;
        div_dividend = r_g;
        div_divisor  = r_d;
        if (r_state == S_TRIAL && r_sq <= SQW'(r_g)) begin
            div_start = 1'b1;
        end else if (r_state == S_RDW && r_large) begin
            div_start   = 1'b1;
            div_divisor = ram_rdata;
        end
    end

    assign ram_we = (r_state == S_DIVW) && div_done && (div_rem == '0)
                    && (r_cnt < CW'(DIVISOR_DEPTH));

    // sequencer next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (i_s_tvalid) n_state = S_GCD;
            S_GCD:    if (r_a == '0 || r_b == '0) n_state = S_TRIAL;
            S_TRIAL:  n_state = (r_sq > SQW'(r_g)) ? S_SELECT : S_DIVW;
            S_DIVW:   if (div_done) n_state = S_TRIAL;
            S_SELECT: n_state = sel_ok ? S_RDW : S_OUT;
            S_RDW:    n_state = r_large ? S_QDIV : S_OUT;
            S_QDIV:   if (div_done) n_state = S_OUT;
            S_OUT:    if (!r_ovalid || i_m_tready) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_cnt    <= '0;
        end else begin
            r_state <= n_state;
            if (r_ovalid && i_m_tready && r_state != S_OUT) r_ovalid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    r_a  <= i_s_tdata[VALUE_BITS-1:0];
                    r_b  <= i_s_tdata[2*VALUE_BITS-1:VALUE_BITS];
                    r_k  <= i_s_tdata[2*VALUE_BITS+RANK_BITS-1:2*VALUE_BITS];
                    r_sh <= '0;
                end
                S_GCD: begin
                    // binary gcd step
                    if (r_a == '0 || r_b == '0) begin
                        r_g      <= (r_a == '0) ? (r_b << r_sh) : (r_a << r_sh);
                        r_d      <= VALUE_BITS'(1);
                        r_sq     <= SQW'(1);
                        r_cnt    <= '0;
                        r_square <= 1'b0;
                    end else if (!r_a[0] && !r_b[0]) begin
                        r_a  <= r_a >> 1;
                        r_b  <= r_b >> 1;
                        r_sh <= r_sh + SW'(1);
                    end else if (!r_a[0]) begin
                        r_a <= r_a >> 1;
                    end else if (!r_b[0]) begin
                        r_b <= r_b >> 1;
                    end else if (r_a >= r_b) begin
                        r_a <= r_a - r_b;
                    end else begin
                        r_b <= r_b - r_a;
                    end
                end
                S_DIVW: begin
                    if (div_done) begin
                        if (ram_we) begin
                            r_cnt    <= r_cnt + CW'(1);
                            r_square <= (r_sq == SQW'(r_g));
                        end
                        r_d  <= r_d + VALUE_BITS'(1);
                        r_sq <= r_sq + SQW'({r_d, 1'b1});
                    end
                end
                S_SELECT: begin
                    r_found <= sel_ok;
                    r_large <= sel_large;
                    r_ans   <= '0;
                end
                S_RDW: begin
                    if (!r_large) r_ans <= ram_rdata;
                end
                S_QDIV: begin
                    if (div_done) r_ans <= div_quo;
                end
                S_OUT: begin
                    if (!r_ovalid || i_m_tready) begin
                        r_ovalid <= 1'b1;
                        r_ofound <= r_found;
                        r_odata  <= r_found ? r_ans : '0;
                    end
                end
                default: ;
            endcase
        end
    end

    kld_div #(.VALUE_BITS(VALUE_BITS)) u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (div_start),
        .i_dividend  (div_dividend),
        .i_divisor   (div_divisor),
        .o_done      (div_done),
        .o_quotient  (div_quo),
        .o_remainder (div_rem)
    );

    kld_ram #(.WIDTH(VALUE_BITS), .DEPTH(DIVISOR_DEPTH)) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_cnt[AW-1:0]),
        .i_wdata (r_d),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = OW'(r_odata);
    assign o_m_tuser  = r_ofound;
endmodule

// ===== design/kld_checker.sv =====
// port-level checks for the kth largest common divisor unit
module kld_assert #(
    parameter int VALUE_BITS = 40
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_s_tvalid,
    input logic                          o_s_tready,
    input logic                          o_m_tvalid,
    input logic                          i_m_tready,
    input logic [((VALUE_BITS+7)/8)*8-1:0] o_m_tdata,
    input logic                          o_m_tuser
);
    // a held result stays offered
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid) else $error("result dropped");

    // not found carries zero, found carries a non-zero divisor
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tuser |-> o_m_tdata == '0) else $error("not found not zero");
    a_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser |-> o_m_tdata != '0) else $error("found zero");

    // one request at a time
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready) else $error("accepted while busy");

    // reset empties the output
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid) else $error("valid after reset");
endmodule

bind kth_largest_common_divisor_unit kld_assert #(.VALUE_BITS(VALUE_BITS)) u_kld_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);
